// ===== rtl/csf_pkg.sv =====
// shared types for the coprime stride finder
`default_nettype none

package csf_pkg;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_START,
      ST_TEST,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic done;
      logic coprime;
   } gcd_status_type;

endpackage

`default_nettype wire

// ===== rtl/csf_gcd_unit.sv =====
// binary gcd unit: one shift or one compare-and-subtract per cycle
`default_nettype none

module csf_gcd_unit
   import csf_pkg::*;
#(
   parameter int VALUE_WIDTH = 32
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   input  wire logic [VALUE_WIDTH-1:0] left_value,
   input  wire logic [VALUE_WIDTH-1:0] right_value,
   output gcd_status_type              status
);

   logic [VALUE_WIDTH-1:0] a_ff, a_in;
   logic [VALUE_WIDTH-1:0] b_ff, b_in;
   logic                   run_ff, run_in;
   logic                   a_greater;
   logic [VALUE_WIDTH-1:0] hi_value;
   logic [VALUE_WIDTH-1:0] lo_value;
   logic [VALUE_WIDTH-1:0] diff_value;
   logic                   meet;

   assign a_greater  = a_ff > b_ff;
   assign hi_value   = a_greater ? a_ff : b_ff;
   assign lo_value   = a_greater ? b_ff : a_ff;
   assign diff_value = hi_value - lo_value;
   assign meet       = run_ff && a_ff[0] && b_ff[0] && (a_ff == b_ff);

   always_comb begin
      a_in   = a_ff;
      b_in   = b_ff;
      run_in = run_ff;
      if (start) begin
         a_in   = left_value;
         b_in   = right_value;
         run_in = 1'b1;
      end else if (run_ff) begin
         if (!a_ff[0]) begin
            a_in = a_ff >> 1;
         end else if (!b_ff[0]) begin
            b_in = b_ff >> 1;
         end else if (a_ff == b_ff) begin
            run_in = 1'b0;
         end else begin
            a_in = diff_value;
            b_in = lo_value;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
      end else begin
         run_ff <= run_in;
      end
      a_ff <= a_in;
      b_ff <= b_in;
   end

   assign status.done    = meet;
   assign status.coprime = meet && (a_ff == {{(VALUE_WIDTH-1){1'b0}}, 1'b1});

endmodule

`default_nettype wire

// ===== rtl/coprime_stride_finder.sv =====
// top level: candidate sequencer around the shared gcd unit
// Answers, for each size, the smallest x with size/2 <= x < size that is coprime to
// size (1 for sizes up to 2). Each item is held until its answer is found; sizes up
// to 2 go straight to the finish state. Otherwise each candidate takes a gcd start,
// the trailing-zero shifts and subtract steps of the gcd unit, and the final compare.
// The answer waits in an output register, and the next size is taken once it is loaded;
// while an earlier answer is still waiting there, the block stalls in its last cycle.
`default_nettype none

module coprime_stride_finder
   import csf_pkg::*;
#(
   parameter int VALUE_WIDTH = 32
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_tvalid,
   output logic                                      req_tready,
   input  wire logic [((VALUE_WIDTH+7)/8)*8-1:0]     req_tdata,  // size
   output logic                                      rsp_tvalid,
   input  wire logic                                 rsp_tready,
   output logic      [((VALUE_WIDTH+7)/8)*8-1:0]     rsp_tdata   // coprime
);

   localparam int DATA_WIDTH = ((VALUE_WIDTH+7)/8)*8;

   state_type              state_ff, state_in;
   logic [VALUE_WIDTH-1:0] size_ff, size_in;
   logic [VALUE_WIDTH-1:0] cand_ff, cand_in;
   logic                   two_ff, two_in;
   logic [VALUE_WIDTH-1:0] result_ff, result_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [VALUE_WIDTH-1:0] rsp_data_ff, rsp_data_in;

   logic [VALUE_WIDTH-1:0] req_size;
   logic                   req_small;
   logic [VALUE_WIDTH:0]   cand_next;
   logic                   cand_over;
   logic                   out_free;
   logic                   gcd_start;
   gcd_status_type         gcd_status;

   assign req_size  = req_tdata[VALUE_WIDTH-1:0];
   assign req_small = req_size <= VALUE_WIDTH'(2);
   assign cand_next = {1'b0, cand_ff} + (two_ff ? (VALUE_WIDTH+1)'(2) : (VALUE_WIDTH+1)'(1));
   assign cand_over = cand_next >= {1'b0, size_ff};
   assign out_free  = !rsp_valid_ff || rsp_tready;

   csf_gcd_unit #(
      .VALUE_WIDTH(VALUE_WIDTH)
   ) u_gcd (
      .clock      (clock),
      .reset      (reset),
      .start      (gcd_start),
      .left_value (cand_ff),
      .right_value(size_ff),
      .status     (gcd_status)
   );

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = req_small ? ST_FINISH : ST_START;
            end
         end
         ST_START: state_in = ST_TEST;
         ST_TEST: begin
            if (gcd_status.done) begin
               state_in = (gcd_status.coprime || cand_over) ? ST_FINISH : ST_START;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_tready   = 1'b0;
      gcd_start    = 1'b0;
      size_in      = size_ff;
      cand_in      = cand_ff;
      two_in       = two_ff;
      result_in    = result_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            size_in    = req_size;
            two_in     = !req_size[0];
            cand_in    = (req_size >> 1) | {{(VALUE_WIDTH-1){1'b0}}, !req_size[0]};
            result_in  = {{(VALUE_WIDTH-1){1'b0}}, 1'b1};
         end
         ST_START: gcd_start = 1'b1;
         ST_TEST: begin
            if (gcd_status.done) begin
               if (gcd_status.coprime) begin
                  result_in = cand_ff;
               end else if (cand_over) begin
                  result_in = '0;
               end else begin
                  cand_in = cand_next[VALUE_WIDTH-1:0];
               end
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = result_ff;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      size_ff     <= size_in;
      cand_ff     <= cand_in;
      two_ff      <= two_in;
      result_ff   <= result_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = DATA_WIDTH'(rsp_data_ff);

endmodule

`default_nettype wire
